FILE: sv/ps2md_pkg.sv
`timescale 1ns / 1ps
package ps2md_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PACKET_LEN  = 3;
    localparam int unsigned AVAIL_BIT   = 5;
    localparam int unsigned IN_WIDTH    = 16;
    localparam int unsigned OUT_WIDTH   = 24;

    typedef enum logic [1:0] {
        KIND_MOVE = 2'd0,
        KIND_DOWN = 2'd1,
        KIND_UP   = 2'd2
    } t_kind;

    // one finished packet, as handed from front to back
    typedef struct packed {
        logic       move;
        logic [7:0] x;
        logic [8:0] y;
        logic [2:0] chg;
        logic [2:0] bits;
    } t_pkt;

endpackage

FILE: sv/ps2md_front.sv
`timescale 1ns / 1ps
module ps2md_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_accept,
    input  logic [7:0]      i_status,
    input  logic [7:0]      i_data,
    output logic            o_push,
    output ps2md_pkg::t_pkt o_pkt
);
    import ps2md_pkg::*;

    logic       r_en, n_en;
    logic [1:0] r_pos, n_pos;
    logic [2:0] r_btn, n_btn;
    logic [7:0] r_b0, n_b0;
    logic [7:0] r_b1, n_b1;
    logic       take;

    assign take = i_accept && i_status[AVAIL_BIT] && r_en;

    always_comb begin
        n_en   = r_en;
        n_pos  = r_pos;
        n_btn  = r_btn;
        n_b0   = r_b0;
        n_b1   = r_b1;
        o_push = 1'b0;
        o_pkt.move = (r_b1 != 8'd0) || (i_data != 8'd0);
        o_pkt.x    = r_b1;
        o_pkt.y    = 9'd0 - {i_data[7], i_data};
        o_pkt.bits = r_b0[2:0];
        o_pkt.chg  = r_b0[2:0] ^ r_btn;
        if (i_cfg_wr_en) begin
            n_en = i_cfg_wr_data;
        end
        if (take) begin
            if (r_pos < 2'(PACKET_LEN - 1)) begin
                if (r_pos[0]) begin
                    n_b1 = i_data;
                end else begin
                    n_b0 = i_data;
                end
                n_pos = r_pos + 2'd1;
            end else begin
                n_pos  = 2'd0;
                n_btn  = r_b0[2:0];
                o_push = o_pkt.move || (o_pkt.chg != 3'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b1;
            r_pos <= 2'd0;
            r_btn <= 3'd0;
        end else begin
            r_en  <= n_en;
            r_pos <= n_pos;
            r_btn <= n_btn;
        end
        r_b0 <= n_b0;
        r_b1 <= n_b1;
    end

endmodule

FILE: sv/ps2md_fifo.sv
`timescale 1ns / 1ps
module ps2md_fifo #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: sv/ps2md_back.sv
`timescale 1ns / 1ps
module ps2md_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  ps2md_pkg::t_pkt i_q_pkt,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_x,
    output logic [8:0]      o_y,
    output logic [1:0]      o_btn,
    output logic            o_last
);
    import ps2md_pkg::*;

    t_pkt       r_cur, n_cur;
    logic       r_have, n_have;
    logic       r_ovalid, n_ovalid;
    t_kind      r_kind, n_kind;
    logic [7:0] r_x, n_x;
    logic [8:0] r_y, n_y;
    logic [1:0] r_btn, n_btn;
    logic       r_last, n_last;

    t_kind      ev_kind;
    logic [7:0] ev_x;
    logic [8:0] ev_y;
    logic [1:0] ev_btn;
    logic [2:0] rem;
    logic       ev_last;
    logic       adv;

    // move first, then changed buttons in order
    always_comb begin
        ev_kind = KIND_MOVE;
        ev_x    = r_cur.x;
        ev_y    = r_cur.y;
        ev_btn  = 2'd0;
        rem     = r_cur.chg;
        if (!r_cur.move) begin
            ev_x = 8'd0;
            ev_y = 9'd0;
            if (r_cur.chg[0]) begin
                ev_btn = 2'd1;
                ev_kind = r_cur.bits[0] ? KIND_DOWN : KIND_UP;
                rem = r_cur.chg & 3'b110;
            end else if (r_cur.chg[1]) begin
                ev_btn = 2'd2;
                ev_kind = r_cur.bits[1] ? KIND_DOWN : KIND_UP;
                rem = r_cur.chg & 3'b100;
            end else begin
                ev_btn = 2'd3;
                ev_kind = r_cur.bits[2] ? KIND_DOWN : KIND_UP;
                rem = 3'b000;
            end
        end
        ev_last = (rem == 3'd0);
    end

    assign adv = !r_ovalid || i_ready;

    always_comb begin
        n_cur    = r_cur;
        n_have   = r_have;
        n_ovalid = r_ovalid;
        n_kind   = r_kind;
        n_x      = r_x;
        n_y      = r_y;
        n_btn    = r_btn;
        n_last   = r_last;
        o_q_pop  = 1'b0;
        if (adv) begin
            n_ovalid = r_have;
            if (r_have) begin
                n_kind     = ev_kind;
                n_x        = ev_x;
                n_y        = ev_y;
                n_btn      = ev_btn;
                n_last     = ev_last;
                n_cur.move = 1'b0;
                n_cur.chg  = rem;
                if (ev_last) begin
                    n_have = 1'b0;
                end
            end
        end
        if (!n_have) begin
            n_have  = i_q_valid;
            n_cur   = i_q_pkt;
            o_q_pop = i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_have   <= n_have;
            r_ovalid <= n_ovalid;
        end
        r_cur  <= n_cur;
        r_kind <= n_kind;
        r_x    <= n_x;
        r_y    <= n_y;
        r_btn  <= n_btn;
        r_last <= n_last;
    end

    assign o_valid = r_ovalid;
    assign o_kind  = r_kind;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_btn   = r_btn;
    assign o_last  = r_last;

endmodule

FILE: sv/ps2_mouse_packet_decoder.sv
`timescale 1ns / 1ps
// PS/2 mouse three-byte packet decoder. One status/data word is taken per clock
// while the packet queue has room; a data byte counts only when status bit 5 is
// set and the enable register is 1 (reset value 1). The third byte of a packet
// hands a packet record to a queue of QUEUE_DEPTH entries; the output stage then
// gives one event per clock while the output is not stalled: a move event if
// X or Y is nonzero (Y negated), then a pressed or released event for each
// changed button 1 to 3, tlast on the final one. A packet thus gives 1 to 4
// events; the first is offered once the record has passed the queue and the
// packet register. Packets with no movement and no button change give nothing.
module ps2_mouse_packet_decoder #(
    parameter int unsigned QUEUE_DEPTH = ps2md_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // controller_status, data_byte
    input  logic [ps2md_pkg::IN_WIDTH-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // move_x, move_y, button_number, zero pad
    output logic [ps2md_pkg::OUT_WIDTH-1:0]  m_axis_tdata,
    // event_kind
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import ps2md_pkg::*;

    logic       accept;
    logic       push, pop, q_full, q_valid;
    t_pkt       f_pkt, q_pkt;
    logic [$bits(t_pkt)-1:0] q_raw;
    logic [7:0] ev_x;
    logic [8:0] ev_y;
    logic [1:0] ev_btn;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ps2md_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_status      (s_axis_tdata[7:0]),
        .i_data        (s_axis_tdata[15:8]),
        .o_push        (push),
        .o_pkt         (f_pkt)
    );

    ps2md_fifo #(
        .WIDTH ($bits(t_pkt)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_pkt),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_raw)
    );

    assign q_pkt = t_pkt'(q_raw);

    ps2md_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_pkt   (q_pkt),
        .o_q_pop   (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (m_axis_tuser),
        .o_x       (ev_x),
        .o_y       (ev_y),
        .o_btn     (ev_btn),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, ev_btn, ev_y, ev_x};

endmodule

FILE: sv/ps2md_checker.sv
`timescale 1ns / 1ps
module ps2md_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ps2md_pkg::OUT_WIDTH-1:0] m_axis_tdata,
    input logic [1:0]                      m_axis_tuser,
    input logic                            m_axis_tlast
);
    import ps2md_pkg::*;

    // move events carry no button number
    a_move_no_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_MOVE)) |-> (m_axis_tdata[18:17] == 2'd0))
        else $error("move event with button number");

    // button events carry a button and no movement
    a_button_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_DOWN || m_axis_tuser == KIND_UP))
        |-> (m_axis_tdata[18:17] != 2'd0 && m_axis_tdata[16:0] == 17'd0))
        else $error("button event fields wrong");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("word offered after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("stalled word changed");

endmodule

bind ps2_mouse_packet_decoder ps2md_checker u_ps2md_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: sim/ps2_mouse_packet_decoder_tb.sv
`timescale 1ns / 1ps
module ps2_mouse_packet_decoder_tb;
    import ps2md_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE       = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int WORDS_PER_PHASE = 105;
    localparam int MAX_REPORTS  = 10;
    localparam int X_LSB   = 0;
    localparam int Y_LSB   = 8;
    localparam int BTN_LSB = 17;

    typedef struct {
        t_kind             kind;
        logic signed [7:0] x;
        logic signed [8:0] y;
        logic [1:0]        btn;
        logic              last;
    } t_mouse_event;

    class mouse_event_board;
        bit           enabled;
        logic [7:0]   head_byte;
        logic [7:0]   x_byte;
        int           position;
        logic [2:0]   buttons;
        t_mouse_event pending_events[$];
        int           mismatches;

        function new();
            enabled    = 1'b1;
            position   = 0;
            buttons    = 3'b000;
            mismatches = 0;
        endfunction

        function void note_word(logic [7:0] status, logic [7:0] data);
            t_mouse_event ev;
            t_mouse_event evs[$];
            logic [2:0]   new_bits;
            if (!status[AVAIL_BIT] || !enabled) return;
            if (position == 0) begin
                head_byte = data;
                position  = 1;
                return;
            end
            if (position == 1) begin
                x_byte   = data;
                position = 2;
                return;
            end
            position = 0;
            if (x_byte != 8'd0 || data != 8'd0) begin
                ev.kind = KIND_MOVE;
                ev.x    = x_byte;
                ev.y    = 9'sd0 - $signed({data[7], data});
                ev.btn  = 2'd0;
                ev.last = 1'b0;
                evs.push_back(ev);
            end
            new_bits = head_byte[2:0];
            for (int i = 0; i < 3; i++) begin
                if (new_bits[i] != buttons[i]) begin
                    ev.kind = new_bits[i] ? KIND_DOWN : KIND_UP;
                    ev.x    = 8'sd0;
                    ev.y    = 9'sd0;
                    ev.btn  = 2'(i + 1);
                    ev.last = 1'b0;
                    evs.push_back(ev);
                end
            end
            buttons = new_bits;
            if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
            foreach (evs[k]) pending_events.push_back(evs[k]);
        endfunction

        function void check_event(logic [1:0] kind, logic [7:0] x, logic [8:0] y,
                                  logic [1:0] btn, logic last);
            t_mouse_event want;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected event: kind %0d x %0d y %0d %s",
                             kind, $signed(x), $signed(y),
                             $sformatf("button %0d last %0d", btn, last));
                return;
            end
            want = pending_events.pop_front();
            if (kind !== want.kind || x !== want.x || y !== want.y ||
                btn !== want.btn || last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("event mismatch: expected %s, got %s",
                             $sformatf("kind %0d x %0d y %0d button %0d last %0d",
                                       want.kind, want.x, want.y, want.btn,
                                       want.last),
                             $sformatf("kind %0d x %0d y %0d button %0d last %0d",
                                       kind, $signed(x), $signed(y), btn, last));
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic                 i_cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_WIDTH-1:0]  s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_WIDTH-1:0] m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    mouse_event_board sb = new();
    bit tx_gaps;
    bit rx_gaps;
    int cycles;
    int taken_words;

    ps2_mouse_packet_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // words seen at each edge feed the predictor and the checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(s_axis_tdata[7:0], s_axis_tdata[15:8]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_event(m_axis_tuser, m_axis_tdata[X_LSB +: 8],
                               m_axis_tdata[Y_LSB +: 9], m_axis_tdata[BTN_LSB +: 2],
                               m_axis_tlast);
        end
    end

    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = rx_gaps ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_word(input logic [7:0] status, input logic [7:0] data);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, status};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (status[AVAIL_BIT]) taken_words++;
    endtask

    function automatic logic [7:0] avail_status();
        return 8'($urandom_range(0, 255)) | (8'd1 << AVAIL_BIT);
    endfunction

    function automatic logic [7:0] idle_status();
        return 8'($urandom_range(0, 255)) & ~(8'd1 << AVAIL_BIT);
    endfunction

    task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2);
        send_word(avail_status(), b0);
        send_word(avail_status(), b1);
        send_word(avail_status(), b2);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.enabled = value;
    endtask

    function automatic logic [7:0] move_byte();
        return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(input int words);
        int start;
        logic [7:0] head;
        start = taken_words;
        while (taken_words - start < words) begin
            case ($urandom_range(0, 11))
                0: send_word(idle_status(), 8'($urandom_range(0, 255)));
                1: send_word(avail_status(), 8'($urandom_range(0, 255)));
                2: begin
                    head = {5'($urandom_range(0, 31)), sb.buttons};
                    send_packet(head, move_byte(), move_byte());
                end
                default: send_packet(8'($urandom_range(0, 255)), move_byte(), move_byte());
            endcase
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cycles        <= 0;
        taken_words = 0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        // directed: extremes, both event kinds, ignored words
        write_enable(1'b1);
        send_word(8'hDF, 8'hFF);
        send_word(8'h27, 8'h07);
        send_word(8'hFF, 8'h80);
        send_word(8'h20, 8'h80);
        send_word(8'hFF, 8'hF8);
        send_word(8'h20, 8'h7F);
        send_word(8'h3F, 8'h7F);
        send_packet(8'h00, 8'h00, 8'h00);
        send_word(8'h20, 8'h02);
        send_word(8'h00, 8'hAA);
        send_word(8'h20, 8'h00);
        send_word(8'h20, 8'h01);
        send_packet(8'h05, 8'h01, 8'h00);
        wait_drained();

        // disabled: everything ignored, packet position holds
        write_enable(1'b0);
        send_packet(8'h07, 8'h55, 8'hAA);
        send_word(8'hFF, 8'h01);
        wait_drained();
        write_enable(1'b1);
        send_packet(8'h02, 8'h00, 8'h00);

        random_phase(WORDS_PER_PHASE);
        wait_drained();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        random_phase(WORDS_PER_PHASE);
        wait_drained();
        write_enable(1'b0);
        tx_gaps = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        wait_drained();
        write_enable(1'b1);
        rx_gaps = 1'b1;
        tx_gaps = 1'b0;
        random_phase(WORDS_PER_PHASE);
        wait_drained();
        tx_gaps = 1'b1;
        random_phase(WORDS_PER_PHASE);
        wait_drained();

        if (sb.mismatches == 0 && sb.pending_events.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
